// ===== hw/rtl/button_click_detector_unit_defines.svh =====
// Assertion macros used by the button click detector checker.
// Depends on nothing; included by the checker file with the bare file name.
`ifndef BUTTON_CLICK_DETECTOR_UNIT_DEFINES_SVH
`define BUTTON_CLICK_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcd assertion failed");

`endif

// ===== hw/rtl/bcd_pkg.sv =====
// Shared constants for the button click detector: widths, reset values, codes.
// No dependencies; used by the top level and its checker.
`default_nettype none

package bcd_pkg;

	localparam int SETTLE_WIDTH = 8;
	localparam int TICK_WIDTH = 16;

	localparam int DEB_W = 8;
	localparam int LONG_W = 16;
	localparam int WIN_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_ADDR_W = 2;

	localparam int SCMP_W = (SETTLE_WIDTH > DEB_W) ? SETTLE_WIDTH : DEB_W;
	localparam int LCMP_W = (TICK_WIDTH > LONG_W) ? TICK_WIDTH : LONG_W;
	localparam int WCMP_W = (TICK_WIDTH > WIN_W) ? TICK_WIDTH : WIN_W;

	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 8;
	localparam int OUT_USED_W = 5;

	localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_LEVEL = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_TICKS = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS_TICKS = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_DOUBLE_CLICK_WINDOW = 2'd3;

	localparam logic RST_ACTIVE_LEVEL = 1'b0;
	localparam logic [DEB_W-1:0] RST_DEBOUNCE_TICKS = 8'd3;
	localparam logic [LONG_W-1:0] RST_LONG_PRESS_TICKS = 16'd200;
	localparam logic [WIN_W-1:0] RST_DOUBLE_CLICK_WINDOW = 16'd60;

	typedef logic [1:0] event_t;

	localparam event_t EV_NONE = 2'd0;
	localparam event_t EV_CLICK = 2'd1;
	localparam event_t EV_DOUBLE = 2'd2;
	localparam event_t EV_LONG = 2'd3;

	localparam logic [1:0] PRESS_ONE = 2'd1;
	localparam logic [1:0] PRESS_TWO = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/button_click_detector_unit.sv =====
// Button click detector: debounce, click, double click and long press events.
// Depends on bcd_pkg.
//
// Usage: one raw pin sample per input beat on s_tdata[0]. Every input beat
// yields exactly one output beat carrying the event for that tick, the last
// reported status and the debounced level. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata while no beat is in flight; a write takes effect
// on the next tick.
// Pipeline: an input register, then the result register that the debounce
// and phase logic feeds.
// Throughput: one beat per cycle while the receiver accepts; the debounce
// counter, tick counter and phase machine all update between the registers.
// Reset clears the phase machine and counters, loads the register defaults
// and sets the debounced level to released (inverse of the default active
// level). When the receiver stalls, the result register holds its beat and
// the input register still takes one more beat; after that s_tready drops
// until the result is taken.
`default_nettype none

module button_click_detector_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// s_tdata: [0] raw_level, [7:1] zero
	input  wire logic [bcd_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// m_tdata: [1:0] event_code, [3:2] held_status, [4] clean_level, [7:5] zero
	output logic [bcd_pkg::OUT_DATA_W-1:0]          m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [bcd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [bcd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PRESSED,
		PH_REL_WAIT,
		PH_LONG_WAIT
	} phase_t;

	// Configuration registers.
	logic                             active_q;
	logic [bcd_pkg::DEB_W-1:0]        deb_q;
	logic [bcd_pkg::LONG_W-1:0]       long_q;
	logic [bcd_pkg::WIN_W-1:0]        win_q;

	// Input stage.
	logic                             valid_s1;
	logic                             raw_s1;

	// Detector state.
	phase_t                           phase_q, phase_n;
	logic                             db_q, db_n;
	logic [bcd_pkg::SETTLE_WIDTH-1:0] settle_q, settle_n, settle_inc;
	logic [bcd_pkg::TICK_WIDTH-1:0]   tick_q, tick_n, tick_a;
	logic [1:0]                       press_q, press_n;
	bcd_pkg::event_t                  status_q, status_n, ev;
	logic                             pressed;

	// Result register.
	logic                             m_valid_q;
	logic [bcd_pkg::OUT_DATA_W-1:0]   m_data_q;

	logic                             adv;

	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= bcd_pkg::RST_ACTIVE_LEVEL;
			deb_q    <= bcd_pkg::RST_DEBOUNCE_TICKS;
			long_q   <= bcd_pkg::RST_LONG_PRESS_TICKS;
			win_q    <= bcd_pkg::RST_DOUBLE_CLICK_WINDOW;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bcd_pkg::CFG_ACTIVE_LEVEL:        active_q <= cfg_wdata[0];
				bcd_pkg::CFG_DEBOUNCE_TICKS:      deb_q <= cfg_wdata[bcd_pkg::DEB_W-1:0];
				bcd_pkg::CFG_LONG_PRESS_TICKS:    long_q <= cfg_wdata[bcd_pkg::LONG_W-1:0];
				bcd_pkg::CFG_DOUBLE_CLICK_WINDOW: win_q <= cfg_wdata[bcd_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			raw_s1 <= s_tdata[0];
		end
	end

	always_comb begin
		tick_a = tick_q;
		if (phase_q != PH_IDLE && tick_q != {bcd_pkg::TICK_WIDTH{1'b1}}) begin
			tick_a = tick_q + 1'b1;
		end

		// Debounce: follow the raw level once it has differed long enough.
		db_n       = db_q;
		settle_n   = '0;
		settle_inc = settle_q;
		if (db_q != raw_s1) begin
			if (settle_q != {bcd_pkg::SETTLE_WIDTH{1'b1}}) begin
				settle_inc = settle_q + 1'b1;
			end
			if (bcd_pkg::SCMP_W'(settle_inc) >= bcd_pkg::SCMP_W'(deb_q)) begin
				db_n = raw_s1;
			end else begin
				settle_n = settle_inc;
			end
		end

		pressed  = (db_n == active_q);
		phase_n  = phase_q;
		tick_n   = tick_a;
		press_n  = press_q;
		status_n = status_q;
		ev       = bcd_pkg::EV_NONE;

		unique case (phase_q)
			PH_IDLE: begin
				if (pressed) begin
					phase_n = PH_PRESSED;
					tick_n  = '0;
					press_n = bcd_pkg::PRESS_ONE;
				end else begin
					status_n = bcd_pkg::EV_NONE;
				end
			end
			PH_PRESSED: begin
				if (!pressed) begin
					tick_n  = '0;
					phase_n = PH_REL_WAIT;
				end else if (bcd_pkg::LCMP_W'(tick_a) >= bcd_pkg::LCMP_W'(long_q)) begin
					ev      = bcd_pkg::EV_LONG;
					tick_n  = '0;
					press_n = '0;
					phase_n = PH_LONG_WAIT;
				end
			end
			PH_REL_WAIT: begin
				if (bcd_pkg::WCMP_W'(tick_a) > bcd_pkg::WCMP_W'(win_q)) begin
					if (press_q == bcd_pkg::PRESS_ONE) begin
						ev = bcd_pkg::EV_CLICK;
					end else if (press_q == bcd_pkg::PRESS_TWO) begin
						ev = bcd_pkg::EV_DOUBLE;
					end
					phase_n = PH_IDLE;
					press_n = '0;
				end else if (pressed) begin
					// A third press inside the window still ends as a double click.
					if (press_q != bcd_pkg::PRESS_TWO) begin
						press_n = press_q + 1'b1;
					end
					phase_n = PH_PRESSED;
					tick_n  = '0;
				end
			end
			PH_LONG_WAIT: begin
				if (!pressed) begin
					phase_n = PH_IDLE;
					press_n = '0;
					tick_n  = '0;
				end
			end
			default: ;
		endcase

		if (ev != bcd_pkg::EV_NONE) begin
			status_n = ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			db_q      <= ~bcd_pkg::RST_ACTIVE_LEVEL;
			settle_q  <= '0;
			tick_q    <= '0;
			press_q   <= '0;
			status_q  <= bcd_pkg::EV_NONE;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (adv) begin
				phase_q   <= phase_n;
				db_q      <= db_n;
				settle_q  <= settle_n;
				tick_q    <= tick_n;
				press_q   <= press_n;
				status_q  <= status_n;
				m_valid_q <= 1'b1;
				m_data_q  <= {(bcd_pkg::OUT_DATA_W - bcd_pkg::OUT_USED_W)'(0), db_n, status_n, ev};
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bcd_checker.sv =====
// Port-level checker for the button click detector and its bind statement.
// Depends on bcd_pkg and button_click_detector_unit_defines.svh.
`default_nettype none

`include "button_click_detector_unit_defines.svh"

module bcd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [bcd_pkg::IN_DATA_W-1:0] s_tdata,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [bcd_pkg::OUT_DATA_W-1:0] m_tdata
);

	// A beat reporting an event also shows that event as the held status.
	`BCD_ASSERT_IMPLY(a_status_follows_event, clk, arst_n, m_tvalid && m_tdata[1:0] != bcd_pkg::EV_NONE, m_tdata[3:2] == m_tdata[1:0])

	// With the result register empty the block must take a beat.
	`BCD_ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)

	// Padding bits above the fields stay zero.
	`BCD_ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[bcd_pkg::OUT_DATA_W-1:bcd_pkg::OUT_USED_W] == '0)

	// A stalled result beat holds.
	`BCD_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind button_click_detector_unit bcd_checker u_bcd_checker (.*);

`default_nettype wire
